>>> rtl/core/backtrackable_pair_hash_set_macros.svh
// Assertion helpers for the hash set RTL.
`ifndef BACKTRACKABLE_PAIR_HASH_SET_MACROS_SVH
`define BACKTRACKABLE_PAIR_HASH_SET_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPHS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bphs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bphs_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TARGET_W = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TARGET = 2'd1,
    ST_FULL       = 2'd2
  } status_e;

  typedef struct packed {
    logic    latch;
    logic    clr_wr;
    logic    pop_rd;
    logic    pop_wr;
    logic    head_rd;
    logic    ins_wr;
    logic    walk_ld_head;
    logic    walk_ld_link;
    logic    walk_rd;
    logic    resp;
    status_e code;
    logic    found;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic target_bad;
    logic need_pop;
    logic full;
    logic is_insert;
    logic is_check;
    logic idx_live;
    logic match;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/bphs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bphs_req_if #(
  parameter int unsigned ATOM_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [bphs_pkg::OP_W-1:0]     op;
  logic [bphs_pkg::TARGET_W-1:0] target_count;
  logic [ATOM_BITS-1:0]          functor_atom;
  logic [ATOM_BITS-1:0]          argument_atom;

  modport source (output valid, op, target_count, functor_atom, argument_atom, input ready);
  modport sink   (input valid, op, target_count, functor_atom, argument_atom, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bphs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bphs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bphs_pkg::STATUS_W-1:0] status;
  logic                          found;
  logic [bphs_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, status, found, entry_total, input ready);
  modport sink   (input valid, status, found, entry_total, output ready);
endinterface
`default_nettype wire

>>> rtl/core/backtrackable_pair_hash_set.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload                                              | Handshake
// req_i   | in  | op, target_count, functor_atom, argument_atom        | valid/ready
// rsp_o   | out | status, found, entry_total                           | valid/ready
//
// After reset a clearing pass writes the null marker to every bucket head,
// with req_i.ready low throughout.
// A request is accepted, then evaluated; each popped entry takes a trail read, a head
// write and a re-evaluate. Insert then reads the bucket head and writes the entry;
// check reads the bucket head and compares chain entries. A result step follows.
// The result cycle waits while rsp_o holds an unaccepted result; the block then
// takes the next request even if rsp_o is still stalled.
module backtrackable_pair_hash_set #(
  parameter int unsigned TRAIL_DEPTH  = 1024,
  parameter int unsigned BUCKET_COUNT = 256,
  parameter int unsigned ATOM_BITS    = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bphs_req_if.sink   req_i,
  bphs_rsp_if.source rsp_o
);

  bphs_pkg::cmd_t  cmd;
  bphs_pkg::stat_t stat;

  // sequencer: walks pop, insert and chain steps for each request
  bphs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // trail, bucket heads, count and the result register
  bphs_dp #(
    .TRAIL_DEPTH  (TRAIL_DEPTH),
    .BUCKET_COUNT (BUCKET_COUNT),
    .ATOM_BITS    (ATOM_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (req_i.op),
    .target_i    (req_i.target_count),
    .functor_i   (req_i.functor_atom),
    .argument_i  (req_i.argument_atom),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status),
    .found_o     (rsp_o.found),
    .total_o     (rsp_o.entry_total)
  );

endmodule
`default_nettype wire

>>> rtl/core/bphs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "backtrackable_pair_hash_set_macros.svh"
module bphs_dp #(
  parameter int unsigned TRAIL_DEPTH  = 1024,
  parameter int unsigned BUCKET_COUNT = 256,
  parameter int unsigned ATOM_BITS    = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bphs_pkg::cmd_t                cmd_i,
  output      bphs_pkg::stat_t               stat_o,
  input  wire logic [bphs_pkg::OP_W-1:0]     op_i,
  input  wire logic [bphs_pkg::TARGET_W-1:0] target_i,
  input  wire logic [ATOM_BITS-1:0]          functor_i,
  input  wire logic [ATOM_BITS-1:0]          argument_i,
  input  wire logic                          out_ready_i,
  output      logic                          out_valid_o,
  output      logic [bphs_pkg::STATUS_W-1:0] status_o,
  output      logic                          found_o,
  output      logic [bphs_pkg::TOTAL_W-1:0]  total_o
);

  localparam int unsigned AW   = $clog2(TRAIL_DEPTH);
  localparam int unsigned CW   = $clog2(TRAIL_DEPTH + 1);
  localparam int unsigned BW   = $clog2(BUCKET_COUNT);
  localparam int unsigned CMPW = (CW > bphs_pkg::TARGET_W) ? CW : bphs_pkg::TARGET_W;
  localparam logic [CW-1:0] NULL_LINK = CW'(TRAIL_DEPTH);

  // fold both atoms into a bucket index; folded value stays below twice the count
  function automatic logic [BW-1:0] bucket_of(input logic [ATOM_BITS-1:0] f,
                                              input logic [ATOM_BITS-1:0] a);
    logic [ATOM_BITS-1:0] x;
    logic [BW-1:0]        h;
    x = f ^ {a[ATOM_BITS-2:0], a[ATOM_BITS-1]};
    h = '0;
    for (int k = 0; k < ATOM_BITS; k++) begin
      h[k % BW] = h[k % BW] ^ x[k];
    end
    if ({1'b0, h} >= (BW+1)'(BUCKET_COUNT)) begin
      h = BW'({1'b0, h} - (BW+1)'(BUCKET_COUNT));
    end
    return h;
  endfunction

  logic [bphs_pkg::OP_W-1:0]     op_q;
  logic [bphs_pkg::TARGET_W-1:0] tgt_q;
  logic [ATOM_BITS-1:0]          f_q, a_q;
  logic [CW-1:0]                 count_q, idx_q, head_rd_q;
  logic [BW-1:0]                 clr_q;
  logic [ATOM_BITS-1:0]          rd_f_q, rd_a_q;
  logic [CW-1:0]                 rd_l_q;
  logic                          out_valid_q, found_q;
  logic [bphs_pkg::STATUS_W-1:0] status_q;
  logic [bphs_pkg::TOTAL_W-1:0]  total_q;

  logic [ATOM_BITS-1:0] trail_f [TRAIL_DEPTH];
  logic [ATOM_BITS-1:0] trail_a [TRAIL_DEPTH];
  logic [CW-1:0]        trail_l [TRAIL_DEPTH];
  logic [CW-1:0]        head_mem [BUCKET_COUNT];

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] trail_raddr;
  logic [BW-1:0] req_bucket, pop_bucket, head_waddr;
  logic [CW-1:0] head_wdata;
  logic          head_we;

  assign cnt_m1      = count_q - CW'(1);
  assign trail_raddr = cmd_i.pop_rd ? cnt_m1[AW-1:0] : idx_q[AW-1:0];
  assign req_bucket  = bucket_of(f_q, a_q);
  assign pop_bucket  = bucket_of(rd_f_q, rd_a_q);

  always_comb begin
    head_we    = cmd_i.clr_wr | cmd_i.pop_wr | cmd_i.ins_wr;
    head_waddr = req_bucket;
    head_wdata = count_q;
    if (cmd_i.clr_wr) begin
      head_waddr = clr_q;
      head_wdata = NULL_LINK;
    end else if (cmd_i.pop_wr) begin
      head_waddr = pop_bucket;
      head_wdata = rd_l_q;
    end
  end

  // trail memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      trail_f[count_q[AW-1:0]] <= f_q;
      trail_a[count_q[AW-1:0]] <= a_q;
      trail_l[count_q[AW-1:0]] <= head_rd_q;
    end
    if (cmd_i.pop_rd || cmd_i.walk_rd) begin
      rd_f_q <= trail_f[trail_raddr];
      rd_a_q <= trail_a[trail_raddr];
      rd_l_q <= trail_l[trail_raddr];
    end
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (cmd_i.head_rd) begin
      head_rd_q <= head_mem[req_bucket];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      tgt_q <= target_i;
      f_q   <= functor_i;
      a_q   <= argument_i;
    end
    if (cmd_i.walk_ld_head) begin
      idx_q <= head_rd_q;
    end else if (cmd_i.walk_ld_link) begin
      idx_q <= rd_l_q;
    end
    if (cmd_i.resp) begin
      status_q <= cmd_i.code;
      found_q  <= cmd_i.found;
      total_q  <= bphs_pkg::TOTAL_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + BW'(1);
      if (cmd_i.pop_wr) begin
        count_q <= cnt_m1;
      end else if (cmd_i.ins_wr) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clr_done   = (clr_q == BW'(BUCKET_COUNT - 1));
    stat_o.target_bad = CMPW'(tgt_q) > CMPW'(count_q);
    stat_o.need_pop   = CMPW'(count_q) > CMPW'(tgt_q);
    stat_o.full       = (count_q >= NULL_LINK);
    stat_o.is_insert  = (op_q == bphs_pkg::OP_INSERT);
    stat_o.is_check   = (op_q == bphs_pkg::OP_CHECK);
    stat_o.idx_live   = (idx_q < count_q);
    stat_o.match      = (rd_f_q == f_q) && (rd_a_q == a_q);
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign total_o     = total_q;

  `BPHS_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= NULL_LINK, "count past trail depth")
  `BPHS_ASSERT_NEXT(a_pop_dec, clk_i, rst_ni, cmd_i.pop_wr, count_q == $past(cnt_m1), "pop did not decrement")
  `BPHS_ASSERT_IMPL(a_ins_room, clk_i, rst_ni, cmd_i.ins_wr, count_q < NULL_LINK, "insert into full trail")
  `BPHS_ASSERT_IMPL(a_found_ok, clk_i, rst_ni, out_valid_q && found_q, status_q == bphs_pkg::ST_OK, "found with error status")

endmodule
`default_nettype wire

>>> rtl/core/bphs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bphs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output      logic            req_ready_o,
  input  wire bphs_pkg::stat_t stat_i,
  output      bphs_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EVAL, S_POP_RD, S_POP_WR, S_HEAD_RD, S_HEAD_USE,
    S_WALK_RD, S_WALK_CMP, S_RESP
  } state_e;

  state_e            state_q;
  bphs_pkg::status_e code_q;
  logic              found_q;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.code  = code_q;
    cmd_o.found = found_q;
    case (state_q)
      S_CLR:      cmd_o.clr_wr  = 1'b1;
      S_IDLE:     cmd_o.latch   = req_valid_i;
      S_POP_RD:   cmd_o.pop_rd  = 1'b1;
      S_POP_WR:   cmd_o.pop_wr  = 1'b1;
      S_HEAD_RD:  cmd_o.head_rd = 1'b1;
      S_HEAD_USE: begin
        cmd_o.ins_wr       = stat_i.is_insert;
        cmd_o.walk_ld_head = !stat_i.is_insert;
      end
      S_WALK_RD:  cmd_o.walk_rd = stat_i.idx_live;
      S_WALK_CMP: cmd_o.walk_ld_link = !stat_i.match;
      S_RESP:     cmd_o.resp    = !stat_i.out_busy;
      default:    cmd_o         = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      code_q  <= bphs_pkg::ST_OK;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLR: begin
          if (stat_i.clr_done) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_EVAL;
            code_q  <= bphs_pkg::ST_OK;
            found_q <= 1'b0;
          end
        end
        S_EVAL: begin
          if (stat_i.target_bad) begin
            code_q  <= bphs_pkg::ST_BAD_TARGET;
            state_q <= S_RESP;
          end else if (stat_i.need_pop) begin
            state_q <= S_POP_RD;
          end else if (stat_i.is_insert && stat_i.full) begin
            code_q  <= bphs_pkg::ST_FULL;
            state_q <= S_RESP;
          end else if (stat_i.is_insert || stat_i.is_check) begin
            state_q <= S_HEAD_RD;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_POP_RD:   state_q <= S_POP_WR;
        S_POP_WR:   state_q <= S_EVAL;
        S_HEAD_RD:  state_q <= S_HEAD_USE;
        S_HEAD_USE: state_q <= stat_i.is_insert ? S_RESP : S_WALK_RD;
        S_WALK_RD: begin
          state_q <= stat_i.idx_live ? S_WALK_CMP : S_RESP;
        end
        S_WALK_CMP: begin
          if (stat_i.match) begin
            found_q <= 1'b1;
            state_q <= S_RESP;
          end else begin
            state_q <= S_WALK_RD;
          end
        end
        S_RESP: begin
          if (!stat_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
